### src/mbe_pkg.sv
package mbe_pkg;

    // Widths fixed by the external interface.
    localparam int ITER_W = 16;
    localparam int CFG_W  = 16;

    // Iteration limit after reset.
    localparam logic [CFG_W-1:0] MAX_ITER_RESET = 16'd256;

    // Operand selection for the shared multiplier.
    typedef logic [1:0] mul_sel_t;

    localparam mul_sel_t MUL_RR = 2'd0;
    localparam mul_sel_t MUL_II = 2'd1;
    localparam mul_sel_t MUL_RI = 2'd2;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     sq_r_en;
        logic     sq_i_en;
        logic     cross_en;
        logic     update_en;
    } mbe_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic escape;
    } mbe_status_t;

endpackage

### src/mandelbrot_escape_time_core.sv
// A point that stops at the limit after n steps reports n; one that escapes after n steps
// also reports n, the last pass finding |z|^2 >= 4.
// Each pass uses the one shared signed multiplier in turn for two squares and the cross
// product, and a fourth step then applies the saturating update of z.
// One point is worked on at a time; a request is taken while a result waits.
// Reset (rst_n, asynchronous, active low) empties the block and sets the limit to 256.
module mandelbrot_escape_time_core #(
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] c_real,
    input  logic signed [COORD_WIDTH-1:0] c_imag,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mbe_pkg::ITER_W-1:0]    iteration_count,
    output logic                          last_point_out,
    input  logic                          cfg_we,
    input  logic [mbe_pkg::CFG_W-1:0]     cfg_wdata
);

    mbe_pkg::mbe_ctrl_t   ctl;
    mbe_pkg::mbe_status_t status;

    // Sequencer: handshakes, step counter, limit and output register.
    mbe_sequencer #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_sequencer (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .last_point     (last_point),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .iteration_count(iteration_count),
        .last_point_out (last_point_out),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .ctl            (ctl),
        .status         (status)
    );

    // Datapath: shared multiplier, escape test and z update.
    mbe_datapath #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .c_real(c_real),
        .c_imag(c_imag),
        .ctl   (ctl),
        .status(status)
    );

endmodule

### src/mbe_datapath.sv
module mbe_datapath #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_WIDTH-1:0] c_real,
    input  logic signed [COORD_WIDTH-1:0] c_imag,
    input  mbe_pkg::mbe_ctrl_t            ctl,
    output mbe_pkg::mbe_status_t          status
);

    localparam int W       = COORD_WIDTH;
    localparam int FRAC_W  = W - 4;
    localparam int PROD_W  = 2 * W;
    localparam int ESC_LSB = 2 * FRAC_W + 2;
    localparam int SUM_W   = W + 6;

    logic signed [W-1:0]      c_real_reg;
    logic signed [W-1:0]      c_imag_reg;
    logic signed [W-1:0]      z_real_reg;
    logic signed [W-1:0]      z_imag_reg;
    logic signed [PROD_W-1:0] sq_r_reg;
    logic signed [PROD_W-1:0] sq_i_reg;
    logic signed [PROD_W-1:0] cross_reg;
    logic signed [PROD_W-1:0] diff_reg;
    logic                     escape_reg;

    logic signed [W-1:0]      mul_a;
    logic signed [W-1:0]      mul_b;
    logic signed [PROD_W-1:0] product;
    logic [PROD_W-1:0]        mag_sum;
    logic signed [PROD_W-1:0] sq_diff;
    logic signed [W+3:0]      new_real_raw;
    logic signed [W+4:0]      new_imag_raw;
    logic signed [SUM_W-1:0]  real_sum;
    logic signed [SUM_W-1:0]  imag_sum;

    // Clamp a widened sum back to the coordinate range.
    function automatic logic signed [W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[SUM_W-1:W-1];
        all_zeros = ~|v[SUM_W-1:W-1];
        if (all_ones || all_zeros)
        begin
            sat_coord = v[W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            sat_coord = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            sat_coord = {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    // Shared multiplier: the operands follow the sequencer's selection.
    always_comb
    begin
        case (ctl.mul_sel)
            mbe_pkg::MUL_RR:
            begin
                mul_a = z_real_reg;
                mul_b = z_real_reg;
            end
            mbe_pkg::MUL_II:
            begin
                mul_a = z_imag_reg;
                mul_b = z_imag_reg;
            end
            mbe_pkg::MUL_RI:
            begin
                mul_a = z_real_reg;
                mul_b = z_imag_reg;
            end
            default:
            begin
                mul_a = z_real_reg;
                mul_b = z_imag_reg;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Escape test and real-part difference, both from the registered squares.
    assign mag_sum = $unsigned(sq_r_reg) + $unsigned(sq_i_reg);
    assign sq_diff = sq_r_reg - sq_i_reg;

    // Scale back to Q4 by arithmetic shifts; the cross term carries the factor of two.
    assign new_real_raw = diff_reg[PROD_W-1:FRAC_W];
    assign new_imag_raw = cross_reg[PROD_W-1:FRAC_W-1];

    assign real_sum = SUM_W'(new_real_raw) + SUM_W'(c_real_reg);
    assign imag_sum = SUM_W'(new_imag_raw) + SUM_W'(c_imag_reg);

    // Working registers of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_real_reg <= '0;
            z_imag_reg <= '0;
            escape_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                z_real_reg <= '0;
                z_imag_reg <= '0;
                escape_reg <= 1'b0;
            end
            else if (ctl.update_en)
            begin
                z_real_reg <= sat_coord(real_sum);
                z_imag_reg <= sat_coord(imag_sum);
            end
            if (ctl.cross_en)
            begin
                escape_reg <= |mag_sum[PROD_W-1:ESC_LSB];
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            c_real_reg <= c_real;
            c_imag_reg <= c_imag;
        end
        if (ctl.sq_r_en)
        begin
            sq_r_reg <= product;
        end
        if (ctl.sq_i_en)
        begin
            sq_i_reg <= product;
        end
        if (ctl.cross_en)
        begin
            cross_reg <= product;
            diff_reg  <= sq_diff;
        end
    end

    assign status.escape = escape_reg;

    // A square can never come out negative.
    a_sq_r_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sq_r_en |=> !sq_r_reg[PROD_W-1])
        else $error("real square negative");

    a_sq_i_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sq_i_en |=> !sq_i_reg[PROD_W-1])
        else $error("imaginary square negative");

    // z must never be advanced once the point has escaped.
    a_no_update_escaped: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update_en |-> !escape_reg)
        else $error("z updated after escape");

endmodule

### src/mbe_sequencer.sv
module mbe_sequencer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             last_point,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mbe_pkg::ITER_W-1:0]       iteration_count,
    output logic                             last_point_out,
    input  logic                             cfg_we,
    input  logic [mbe_pkg::CFG_W-1:0]        cfg_wdata,
    output mbe_pkg::mbe_ctrl_t               ctl,
    input  mbe_pkg::mbe_status_t             status
);

    localparam int LIM_W = (COUNT_WIDTH > mbe_pkg::CFG_W) ? COUNT_WIDTH : mbe_pkg::CFG_W;
    localparam logic [LIM_W-1:0] CAP = LIM_W'({COUNT_WIDTH{1'b1}});

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_I,
        ST_CROSS,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [COUNT_WIDTH-1:0]     count_reg;
    logic [COUNT_WIDTH-1:0]     count_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [mbe_pkg::ITER_W-1:0] out_count_reg;
    logic [mbe_pkg::ITER_W-1:0] out_count_next;
    logic                       out_last_reg;
    logic                       out_last_next;
    logic [mbe_pkg::CFG_W-1:0]  max_iter_reg;
    logic [mbe_pkg::CFG_W-1:0]  max_iter_next;

    logic [LIM_W-1:0]           max_wide;
    logic [LIM_W-1:0]           limit_wide;
    logic [LIM_W-1:0]           count_wide;
    logic [LIM_W-1:0]           count_inc;
    logic                       accept;
    logic                       out_free;

    // Effective limit, clamped to what the step counter can hold.
    assign max_wide   = LIM_W'(max_iter_reg);
    assign limit_wide = (max_wide > CAP) ? CAP : max_wide;
    assign count_wide = LIM_W'(count_reg);
    assign count_inc  = count_wide + LIM_W'(1);

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and next register values.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        max_iter_next  = cfg_we ? cfg_wdata : max_iter_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    count_next = '0;
                    last_next  = last_point;
                    state_next = (limit_wide != '0) ? ST_SQ_R : ST_FINISH;
                end
            end
            ST_SQ_R:
            begin
                state_next = ST_SQ_I;
            end
            ST_SQ_I:
            begin
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.escape)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    count_next = count_inc[COUNT_WIDTH-1:0];
                    state_next = (count_inc < limit_wide) ? ST_SQ_R : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_wide[mbe_pkg::ITER_W-1:0];
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counter, output register and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_last_reg  <= 1'b0;
            max_iter_reg  <= mbe_pkg::MAX_ITER_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            out_last_reg  <= out_last_next;
            max_iter_reg  <= max_iter_next;
        end
    end

    // Datapath commands decoded from the state.
    always_comb
    begin
        ctl           = '0;
        ctl.load      = accept;
        ctl.mul_sel   = mbe_pkg::MUL_RI;
        ctl.sq_r_en   = (state_reg == ST_SQ_R);
        ctl.sq_i_en   = (state_reg == ST_SQ_I);
        ctl.cross_en  = (state_reg == ST_CROSS);
        ctl.update_en = (state_reg == ST_UPDATE) && !status.escape;
        case (state_reg)
            ST_SQ_R:
            begin
                ctl.mul_sel = mbe_pkg::MUL_RR;
            end
            ST_SQ_I:
            begin
                ctl.mul_sel = mbe_pkg::MUL_II;
            end
            default:
            begin
                ctl.mul_sel = mbe_pkg::MUL_RI;
            end
        endcase
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign iteration_count = out_count_reg;
    assign last_point_out  = out_last_reg;

    // A new point is never taken while one is being worked on.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while busy");

    // While iterating, the step count stays below the limit, if the limit is not written meanwhile.
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SQ_R) || (state_reg == ST_SQ_I) ||
         (state_reg == ST_CROSS) || (state_reg == ST_UPDATE)) |-> (count_wide < limit_wide))
        else $error("step count beyond limit");

    // A finished point lands in a free output register at once.
    a_finish_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_valid_reg) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished point not delivered");

endmodule
